FILE: rtl/queued_char_lcd_nibble_writer_top_macros.svh
// Assertion macros used by the nibble writer checker
`ifndef QUEUED_CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH
`define QUEUED_CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low
`define QCLNW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds its value in the cycle after the condition
`define QCLNW_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  `QCLNW_ASSERT(lbl, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

FILE: rtl/qclnw_pkg.sv
// Shared widths, register indexes and result bit positions of the nibble writer
`timescale 1ns / 1ps

package qclnw_pkg;

  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned ENTRY_W    = 10;
  localparam int unsigned FREE_W     = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_WAIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT   = 1'b1;

  // Result tdata bit positions
  localparam int unsigned OUT_RS   = 0;
  localparam int unsigned OUT_E    = 1;
  localparam int unsigned OUT_NIB  = 2;
  localparam int unsigned OUT_ACC  = 6;
  localparam int unsigned OUT_BUSY = 7;
  localparam int unsigned OUT_TICK = 8;
  localparam int unsigned OUT_FREE = 9;

  // Queue entry: rs, long wait, byte
  typedef struct packed {
    logic       rs;
    logic       ext_wait;
    logic [7:0] byte_value;
  } entry_t;

endpackage

FILE: rtl/queued_char_lcd_nibble_writer_top.sv
// Queued character display writer: op queue plus tick-driven 4-bit bus sequencer
//
// Input stream (s_axis): tuser selects the item kind, 0 enqueues the operation in
// tdata, 1 is one timer tick. An enqueue into a full queue is dropped.
// Output stream (m_axis): one result per input item: the bus pin levels, the
// accepted flag, busy, tick request and free queue slots after that item.
// Each tick advances the sequencer one step: pop and drive RS, high nibble, E high;
// E low; low nibble, E high; E low and load the post-byte wait; count down.
// Output: the result is registered and is on m_axis in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the queue memory read for the
// next head is issued every cycle, so a pop never waits on the memory port.
// Stall: the result register holds while m_axis_tready is low and s_axis_tready
// drops until the result is taken; no item is lost or repeated.
// Reset: queue empty, sequencer idle, pins low, busy and tick request clear,
// wait registers back to 1 and 20. Queue contents are not cleared; no clear pass.
// Configuration: cfg_we_i writes register cfg_idx_i in the same cycle.
`timescale 1ns / 1ps

module queued_char_lcd_nibble_writer_top #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qclnw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qclnw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] reg_select, [8:1] byte_value, [9] ext_wait, [15:10] zero
  input  logic [qclnw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] rs_pin, [1] enable_pin, [5:2] nibble_pins, [6] accepted, [7] busy_res,
  // [8] tick_request, [15:9] free_slots
  output logic [qclnw_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HI_E1 = 3'd1;
  localparam logic [2:0] PH_HI_E0 = 3'd2;
  localparam logic [2:0] PH_LO_E1 = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  // configuration
  logic [7:0] normal_wait_q, ext_wait_q;

  // sequencer state
  logic [2:0] phase_q, phase_d;
  logic [3:0] cur_lo_q, cur_lo_d;
  logic       cur_long_q, cur_long_d;
  logic [7:0] wait_q, wait_d;
  logic       busy_q, busy_d;
  logic       timer_q, timer_d;
  logic       pin_rs_q, pin_rs_d;
  logic       pin_e_q, pin_e_d;
  logic [3:0] pin_nib_q, pin_nib_d;

  // queue
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  qclnw_pkg::entry_t mem [QUEUE_DEPTH];
  qclnw_pkg::entry_t mem_rd_q, fwd_data_q, head, wr_entry;
  logic              fwd_q;

  // output stage
  logic                            out_valid_q;
  logic [qclnw_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  logic        in_fire, is_tick, do_wr, pop, full, empty, accepted;
  logic [31:0] free_full;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = s_axis_tuser;
  assign full          = (count_q == CNT_FULL);
  assign empty         = (count_q == '0);
  assign do_wr         = in_fire && !is_tick && !full;
  assign accepted      = do_wr;

  assign wr_entry.rs         = s_axis_tdata[0];
  assign wr_entry.byte_value = s_axis_tdata[8:1];
  assign wr_entry.ext_wait   = s_axis_tdata[9];

  assign head = fwd_q ? fwd_data_q : mem_rd_q;

  always_comb begin
    phase_d    = phase_q;
    cur_lo_d   = cur_lo_q;
    cur_long_d = cur_long_q;
    wait_d     = wait_q;
    busy_d     = busy_q;
    timer_d    = timer_q;
    pin_rs_d   = pin_rs_q;
    pin_e_d    = pin_e_q;
    pin_nib_d  = pin_nib_q;
    pop        = 1'b0;
    if (do_wr) begin
      busy_d  = 1'b1;
      timer_d = 1'b1;
    end else if (in_fire && is_tick) begin
      case (phase_q)
        PH_IDLE: begin
          if (empty) begin
            busy_d  = 1'b0;
            timer_d = 1'b0;
          end else begin
            pop        = 1'b1;
            cur_lo_d   = head.byte_value[3:0];
            cur_long_d = head.ext_wait;
            pin_rs_d   = head.rs;
            pin_nib_d  = head.byte_value[7:4];
            pin_e_d    = 1'b1;
            phase_d    = PH_HI_E1;
          end
        end
        PH_HI_E1: begin
          pin_e_d = 1'b0;
          phase_d = PH_HI_E0;
        end
        PH_HI_E0: begin
          pin_nib_d = cur_lo_q;
          pin_e_d   = 1'b1;
          phase_d   = PH_LO_E1;
        end
        PH_LO_E1: begin
          pin_e_d = 1'b0;
          wait_d  = cur_long_q ? ext_wait_q : normal_wait_q;
          phase_d = PH_WAIT;
        end
        PH_WAIT: begin
          // a zero load wraps here and runs a full 256 ticks
          wait_d = wait_q - 8'd1;
          if (wait_d == 8'd0) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_idx_d = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + IDX_W'(1);
      count_d  = count_q + CNT_W'(1);
    end
    if (pop) begin
      rd_idx_d = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + IDX_W'(1);
      count_d  = count_q - CNT_W'(1);
    end
  end

  assign free_full = 32'(QUEUE_DEPTH) - 32'(count_d);

  always_comb begin
    out_data_d                                 = '0;
    out_data_d[qclnw_pkg::OUT_RS]              = pin_rs_d;
    out_data_d[qclnw_pkg::OUT_E]               = pin_e_d;
    out_data_d[qclnw_pkg::OUT_NIB +: 4]        = pin_nib_d;
    out_data_d[qclnw_pkg::OUT_ACC]             = accepted;
    out_data_d[qclnw_pkg::OUT_BUSY]            = busy_d;
    out_data_d[qclnw_pkg::OUT_TICK]            = timer_d;
    out_data_d[qclnw_pkg::OUT_FREE +: qclnw_pkg::FREE_W] = free_full[qclnw_pkg::FREE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_wait_q <= 8'd1;
      ext_wait_q    <= 8'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qclnw_pkg::REG_NORMAL_WAIT: normal_wait_q <= cfg_data_i;
        qclnw_pkg::REG_LONG_WAIT:   ext_wait_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cur_lo_q    <= '0;
      cur_long_q  <= 1'b0;
      wait_q      <= '0;
      busy_q      <= 1'b0;
      timer_q     <= 1'b0;
      pin_rs_q    <= 1'b0;
      pin_e_q     <= 1'b0;
      pin_nib_q   <= '0;
      count_q     <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cur_lo_q   <= cur_lo_d;
      cur_long_q <= cur_long_d;
      wait_q     <= wait_d;
      busy_q     <= busy_d;
      timer_q    <= timer_d;
      pin_rs_q   <= pin_rs_d;
      pin_e_q    <= pin_e_d;
      pin_nib_q  <= pin_nib_d;
      count_q    <= count_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      // write to the slot being read: take the new entry, not the stale word
      fwd_q      <= do_wr && (wr_idx_q == rd_idx_d);
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  // queue memory, head word read every cycle
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_idx_q] <= wr_entry;
    end
    mem_rd_q   <= mem[rd_idx_d];
    fwd_data_q <= wr_entry;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/qclnw_checker.sv
// Port-level checker for the nibble writer, bound to the top level
`timescale 1ns / 1ps
`include "queued_char_lcd_nibble_writer_top_macros.svh"

module qclnw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [qclnw_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic out_stall, s_xfer;
  logic res_acc, res_busy, res_tick, res_e;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign s_xfer    = s_axis_tvalid && s_axis_tready;
  assign res_acc   = m_axis_tdata[qclnw_pkg::OUT_ACC];
  assign res_busy  = m_axis_tdata[qclnw_pkg::OUT_BUSY];
  assign res_tick  = m_axis_tdata[qclnw_pkg::OUT_TICK];
  assign res_e     = m_axis_tdata[qclnw_pkg::OUT_E];

  `QCLNW_ASSERT_HOLD(a_valid_hold, clk_i, rst_ni, out_stall, m_axis_tvalid, "result dropped while stalled")
  `QCLNW_ASSERT_HOLD(a_data_hold, clk_i, rst_ni, out_stall, m_axis_tdata, "result changed while stalled")
  `QCLNW_ASSERT(a_result_follows, clk_i, rst_ni, s_xfer |=> m_axis_tvalid, "no result after input transfer")
  `QCLNW_ASSERT(a_accept_busy, clk_i, rst_ni, (m_axis_tvalid && res_acc) |-> (res_busy && res_tick), "stored enqueue without busy and tick request")
  `QCLNW_ASSERT(a_strobe_busy, clk_i, rst_ni, (m_axis_tvalid && res_e) |-> res_busy, "enable strobe high while not busy")

endmodule

bind queued_char_lcd_nibble_writer_top qclnw_checker u_qclnw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
